// ===== hdl/rtch_pkg.sv =====
package rtch_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned DIR_W           = 18;
  localparam int unsigned DIST_W          = 31;
  localparam int unsigned QUO_W           = 32;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned NSTEPS          = 24;
  localparam int unsigned STEP_W          = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  typedef enum logic [1:0] {X_D, X_E1, X_P, X_Q} xsel_e;
  typedef enum logic [1:0] {Y_D, Y_E1, Y_E2, Y_T} ysel_e;
  typedef enum logic [2:0] {D_P, D_Q, D_DET, D_UN, D_VN, D_TN} dst_e;

  typedef struct packed {
    xsel_e      xs;
    logic [1:0] xi;
    ysel_e      ys;
    logic [1:0] yi;
    logic       neg;
    logic       flip;
    logic       first;
    logic       last;
    dst_e       dst;
    logic [1:0] di;
  } step_t;

  function automatic int unsigned max2(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic step_t mk(xsel_e xs, logic [1:0] xi, ysel_e ys, logic [1:0] yi,
                               logic neg, logic flip, logic first, logic last,
                               dst_e dst, logic [1:0] di);
    step_t s;
    s.xs = xs; s.xi = xi; s.ys = ys; s.yi = yi;
    s.neg = neg; s.flip = flip; s.first = first; s.last = last;
    s.dst = dst; s.di = di;
    return s;
  endfunction

  // P = D x E2, det = E1.P, un = T.P, Q = T x E1, vn = D.Q, tn = E2.Q
  function automatic step_t step_rom(logic [STEP_W-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:  s = mk(X_D,  2'd1, Y_E2, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0, D_P,   2'd0);
      5'd1:  s = mk(X_D,  2'd2, Y_E2, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, D_P,   2'd0);
      5'd2:  s = mk(X_D,  2'd2, Y_E2, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, D_P,   2'd1);
      5'd3:  s = mk(X_D,  2'd0, Y_E2, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, D_P,   2'd1);
      5'd4:  s = mk(X_D,  2'd0, Y_E2, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0, D_P,   2'd2);
      5'd5:  s = mk(X_D,  2'd1, Y_E2, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1, D_P,   2'd2);
      5'd6:  s = mk(X_P,  2'd0, Y_E1, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, D_DET, 2'd0);
      5'd7:  s = mk(X_P,  2'd1, Y_E1, 2'd1, 1'b0, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
      5'd8:  s = mk(X_P,  2'd2, Y_E1, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, D_DET, 2'd0);
      5'd9:  s = mk(X_P,  2'd0, Y_T,  2'd0, 1'b0, 1'b1, 1'b1, 1'b0, D_UN,  2'd0);
      5'd10: s = mk(X_P,  2'd1, Y_T,  2'd1, 1'b0, 1'b1, 1'b0, 1'b0, D_UN,  2'd0);
      5'd11: s = mk(X_P,  2'd2, Y_T,  2'd2, 1'b0, 1'b1, 1'b0, 1'b1, D_UN,  2'd0);
      5'd12: s = mk(X_E1, 2'd2, Y_T,  2'd1, 1'b0, 1'b0, 1'b1, 1'b0, D_Q,   2'd0);
      5'd13: s = mk(X_E1, 2'd1, Y_T,  2'd2, 1'b1, 1'b0, 1'b0, 1'b1, D_Q,   2'd0);
      5'd14: s = mk(X_E1, 2'd0, Y_T,  2'd2, 1'b0, 1'b0, 1'b1, 1'b0, D_Q,   2'd1);
      5'd15: s = mk(X_E1, 2'd2, Y_T,  2'd0, 1'b1, 1'b0, 1'b0, 1'b1, D_Q,   2'd1);
      5'd16: s = mk(X_E1, 2'd1, Y_T,  2'd0, 1'b0, 1'b0, 1'b1, 1'b0, D_Q,   2'd2);
      5'd17: s = mk(X_E1, 2'd0, Y_T,  2'd1, 1'b1, 1'b0, 1'b0, 1'b1, D_Q,   2'd2);
      5'd18: s = mk(X_Q,  2'd0, Y_D,  2'd0, 1'b0, 1'b1, 1'b1, 1'b0, D_VN,  2'd0);
      5'd19: s = mk(X_Q,  2'd1, Y_D,  2'd1, 1'b0, 1'b1, 1'b0, 1'b0, D_VN,  2'd0);
      5'd20: s = mk(X_Q,  2'd2, Y_D,  2'd2, 1'b0, 1'b1, 1'b0, 1'b1, D_VN,  2'd0);
      5'd21: s = mk(X_Q,  2'd0, Y_E2, 2'd0, 1'b0, 1'b1, 1'b1, 1'b0, D_TN,  2'd0);
      5'd22: s = mk(X_Q,  2'd1, Y_E2, 2'd1, 1'b0, 1'b1, 1'b0, 1'b0, D_TN,  2'd0);
      5'd23: s = mk(X_Q,  2'd2, Y_E2, 2'd2, 1'b0, 1'b1, 1'b0, 1'b1, D_TN,  2'd0);
      default: s = mk(X_D, 2'd0, Y_D, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, D_P, 2'd0);
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/rtch_if.sv =====
interface rtch_tri_if #(parameter int unsigned COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic                          first_of_ray;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;

  modport source (output valid, first_of_ray, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, input ready);
  modport sink   (input valid, first_of_ray, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, output ready);
endinterface

interface rtch_hit_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [rtch_pkg::DIST_W-1:0] hit_distance;
  logic                        nearest_found;
  logic [rtch_pkg::DIST_W-1:0] nearest_distance;

  modport source (output valid, hit, hit_distance, nearest_found, nearest_distance,
                  input ready);
  modport sink   (input valid, hit, hit_distance, nearest_found, nearest_distance,
                  output ready);
endinterface

interface rtch_cfg_if #(parameter int unsigned COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF);
  localparam int unsigned DataW = rtch_pkg::max2(COORD_WIDTH, rtch_pkg::DIR_W);
  logic                             valid;
  logic                             ready;
  logic [rtch_pkg::CFG_IDX_W-1:0]   index;
  logic [DataW-1:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ray_triangle_closest_hit.sv =====
// Channel  Dir  Word
// cfg_i    in   index, data: origin x/y/z, direction x/y/z
// tri_i    in   first_of_ray, vertices a, b, c
// hit_o    out  hit, hit_distance, nearest_found, nearest_distance
//
// The back end works one triangle at a time with the bit-serial
// multiply-accumulate unit and the 32-step divider; a miss skips the divider.
// A two-word queue takes triangles while the back end works; the output
// register holds a result until taken; reset clears config and the record.
module ray_triangle_closest_hit #(
  parameter int unsigned COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtch_cfg_if.sink   cfg_i,
  rtch_tri_if.sink   tri_i,
  rtch_hit_if.source hit_o
);
  import rtch_pkg::*;

  logic [COORD_WIDTH-1:0] origin_q [3];
  logic [DIR_W-1:0]       dir_q    [3];
  logic                   item_valid, item_ready, item_first;
  logic [COORD_WIDTH:0]   item_e1 [3];
  logic [COORD_WIDTH:0]   item_e2 [3];
  logic [COORD_WIDTH:0]   item_t  [3];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '{default: '0};
      dir_q    <= '{default: '0};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ORIGIN_X: origin_q[0] <= cfg_i.data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: origin_q[1] <= cfg_i.data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: origin_q[2] <= cfg_i.data[COORD_WIDTH-1:0];
        REG_DIR_X:    dir_q[0]    <= cfg_i.data[DIR_W-1:0];
        REG_DIR_Y:    dir_q[1]    <= cfg_i.data[DIR_W-1:0];
        REG_DIR_Z:    dir_q[2]    <= cfg_i.data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  rtch_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .origin_i     (origin_q),
    .tri_i        (tri_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_first_o (item_first),
    .item_e1_o    (item_e1),
    .item_e2_o    (item_e2),
    .item_t_o     (item_t)
  );

  rtch_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dir_i        (dir_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_first_i (item_first),
    .item_e1_i    (item_e1),
    .item_e2_i    (item_e2),
    .item_t_i     (item_t),
    .hit_o        (hit_o)
  );

endmodule

// ===== hdl/rtch_front.sv =====
module rtch_front #(
  parameter int unsigned COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [COORD_WIDTH-1:0] origin_i [3],
  rtch_tri_if.sink               tri_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output logic                   item_first_o,
  output logic [COORD_WIDTH:0]   item_e1_o [3],
  output logic [COORD_WIDTH:0]   item_e2_o [3],
  output logic [COORD_WIDTH:0]   item_t_o  [3]
);
  import rtch_pkg::*;

  localparam int unsigned EW = COORD_WIDTH + 1;
  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [COORD_WIDTH-1:0] va [3];
  logic [COORD_WIDTH-1:0] vb [3];
  logic [COORD_WIDTH-1:0] vc [3];
  logic [EW-1:0]          e1 [3];
  logic [EW-1:0]          e2 [3];
  logic [EW-1:0]          tv [3];

  logic [EW-1:0] e1_q    [QUEUE_DEPTH][3];
  logic [EW-1:0] e2_q    [QUEUE_DEPTH][3];
  logic [EW-1:0] tv_q    [QUEUE_DEPTH][3];
  logic          first_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign va = '{tri_i.a_x, tri_i.a_y, tri_i.a_z};
  assign vb = '{tri_i.b_x, tri_i.b_y, tri_i.b_z};
  assign vc = '{tri_i.c_x, tri_i.c_y, tri_i.c_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = {vb[i][COORD_WIDTH-1], vb[i]} - {va[i][COORD_WIDTH-1], va[i]};
      e2[i] = {vc[i][COORD_WIDTH-1], vc[i]} - {va[i][COORD_WIDTH-1], va[i]};
      tv[i] = {origin_i[i][COORD_WIDTH-1], origin_i[i]} - {va[i][COORD_WIDTH-1], va[i]};
    end
  end

  assign tri_i.ready  = cnt_q != CW'(QUEUE_DEPTH);
  assign item_valid_o = cnt_q != '0;
  assign push         = tri_i.valid & tri_i.ready;
  assign pop          = item_valid_o & item_ready_i;

  assign item_first_o = first_q[rd_q];
  assign item_e1_o    = e1_q[rd_q];
  assign item_e2_o    = e2_q[rd_q];
  assign item_t_o     = tv_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      e1_q[wr_q]    <= e1;
      e2_q[wr_q]    <= e2;
      tv_q[wr_q]    <= tv;
      first_q[wr_q] <= tri_i.first_of_ray;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/rtch_back.sv =====
module rtch_back #(
  parameter int unsigned COORD_WIDTH = rtch_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rtch_pkg::DIR_W-1:0] dir_i [3],
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  logic                      item_first_i,
  input  logic [COORD_WIDTH:0]      item_e1_i [3],
  input  logic [COORD_WIDTH:0]      item_e2_i [3],
  input  logic [COORD_WIDTH:0]      item_t_i  [3],
  rtch_hit_if.source                hit_o
);
  import rtch_pkg::*;

  localparam int unsigned EW  = COORD_WIDTH + 1;
  localparam int unsigned YW  = max2(EW, DIR_W);
  localparam int unsigned XW  = max2(2 * COORD_WIDTH + 3, COORD_WIDTH + 20);
  localparam int unsigned AW  = max2(max2(3 * COORD_WIDTH + 6, 2 * COORD_WIDTH + 23), XW + 20);
  localparam int unsigned DVW = max2(AW + FRAC_W, 2 * COORD_WIDTH + 23 + QUO_W - 1);
  localparam int unsigned BW  = $clog2(YW);
  localparam int unsigned QCW = $clog2(QUO_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  logic                    first_q;
  logic signed [EW-1:0]    e1_q [3];
  logic signed [EW-1:0]    e2_q [3];
  logic signed [EW-1:0]    tv_q [3];
  logic signed [XW-1:0]    p_q  [3];
  logic signed [XW-1:0]    q_q  [3];
  logic [AW-1:0]           det_q, un_q, vn_q, tn_q, dt_q;
  logic                    det_neg_q;
  logic [AW-1:0]           acc_q, xs_q;
  logic [YW-1:0]           ys_q;
  logic [BW-1:0]           bit_q;
  logic [STEP_W-1:0]       step_q;
  logic [DVW-1:0]          num_q, ds_q;
  logic [QUO_W-1:0]        quo_q;
  logic [QCW-1:0]          qcnt_q;

  logic                    out_valid_q;
  logic                    hit_q, near_found_q;
  logic [DIST_W-1:0]       dist_q, near_dist_q;
  logic [QUO_W-1:0]        best_q;
  logic                    best_valid_q;

  step_t                   st;
  logic signed [AW-1:0]    x_val;
  logic signed [YW-1:0]    y_val;
  logic                    last_bit, sub;
  logic [AW-1:0]           acc_d;
  logic [AW:0]             uv_sum;
  logic                    miss;
  logic                    ge;
  logic [DIST_W-1:0]       tri_dist;
  logic                    hit;
  logic                    slot_free;
  logic                    base_valid, upd, best_valid_d;
  logic [QUO_W-1:0]        base_best, best_d;

  assign st = step_rom(step_q);

  always_comb begin
    unique case (st.xs)
      X_D:  x_val = AW'($signed(dir_i[st.xi]));
      X_E1: x_val = AW'(e1_q[st.xi]);
      X_P:  x_val = AW'(p_q[st.xi]);
      X_Q:  x_val = AW'(q_q[st.xi]);
    endcase
    unique case (st.ys)
      Y_D:  y_val = YW'($signed(dir_i[st.yi]));
      Y_E1: y_val = YW'(e1_q[st.yi]);
      Y_E2: y_val = YW'(e2_q[st.yi]);
      Y_T:  y_val = YW'(tv_q[st.yi]);
    endcase
  end

  // top bit of the multiplier carries negative weight
  assign last_bit = bit_q == BW'(YW - 1);
  assign sub      = st.neg ^ (st.flip & det_neg_q) ^ last_bit;
  assign acc_d    = ys_q[0] ? acc_q + (xs_q ^ {AW{sub}}) + AW'(sub) : acc_q;

  assign uv_sum = {un_q[AW-1], un_q} + {vn_q[AW-1], vn_q};
  assign miss   = (det_q == '0) | un_q[AW-1] | (un_q > dt_q) | vn_q[AW-1]
                | (uv_sum > {1'b0, dt_q}) | tn_q[AW-1] | (tn_q == '0);

  assign ge = num_q >= ds_q;

  assign tri_dist = quo_q[QUO_W-1] ? '1 : quo_q[DIST_W-1:0];
  assign hit      = tri_dist != '0;

  assign base_valid   = first_q ? 1'b0 : best_valid_q;
  assign base_best    = first_q ? '1 : best_q;
  assign upd          = hit & (!base_valid | ({1'b0, tri_dist} < base_best));
  assign best_valid_d = base_valid | upd;
  assign best_d       = upd ? {1'b0, tri_dist} : base_best;

  assign slot_free    = !out_valid_q | hit_o.ready;
  assign item_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (item_valid_i) state_d = S_LOAD;
      S_LOAD: state_d = S_MUL;
      S_MUL: begin
        if (last_bit) begin
          state_d = (step_q == STEP_W'(NSTEPS - 1)) ? S_ABS : S_LOAD;
        end
      end
      S_ABS: state_d = S_CHK;
      S_CHK: state_d = miss ? S_DONE : S_DIV;
      S_DIV: if (qcnt_q == QCW'(QUO_W - 1)) state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          first_q <= item_first_i;
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= $signed(item_e1_i[i]);
            e2_q[i] <= $signed(item_e2_i[i]);
            tv_q[i] <= $signed(item_t_i[i]);
          end
          step_q <= '0;
        end
      end
      S_LOAD: begin
        xs_q  <= x_val;
        ys_q  <= y_val;
        bit_q <= '0;
        if (st.first) acc_q <= '0;
      end
      S_MUL: begin
        acc_q <= acc_d;
        xs_q  <= xs_q << 1;
        ys_q  <= ys_q >> 1;
        bit_q <= bit_q + BW'(1);
        if (last_bit) begin
          step_q <= step_q + STEP_W'(1);
          if (st.last) begin
            unique case (st.dst)
              D_P:   p_q[st.di] <= $signed(acc_d[XW-1:0]);
              D_Q:   q_q[st.di] <= $signed(acc_d[XW-1:0]);
              D_DET: begin
                det_q     <= acc_d;
                det_neg_q <= acc_d[AW-1];
              end
              D_UN:  un_q <= acc_d;
              D_VN:  vn_q <= acc_d;
              D_TN:  tn_q <= acc_d;
              default: ;
            endcase
          end
        end
      end
      S_ABS: dt_q <= det_neg_q ? -det_q : det_q;
      S_CHK: begin
        num_q  <= DVW'({tn_q, {FRAC_W{1'b0}}});
        ds_q   <= DVW'(dt_q) << (QUO_W - 1);
        qcnt_q <= '0;
        quo_q  <= '0;
      end
      S_DIV: begin
        if (ge) num_q <= num_q - ds_q;
        ds_q   <= ds_q >> 1;
        quo_q  <= {quo_q[QUO_W-2:0], ge};
        qcnt_q <= qcnt_q + QCW'(1);
      end
      S_DONE: begin
        if (slot_free) begin
          hit_q        <= hit;
          dist_q       <= tri_dist;
          near_found_q <= best_valid_d;
          near_dist_q  <= best_valid_d ? best_d[DIST_W-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      best_q       <= '1;
      best_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && slot_free) begin
        out_valid_q  <= 1'b1;
        best_q       <= best_d;
        best_valid_q <= best_valid_d;
      end else if (hit_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign hit_o.valid            = out_valid_q;
  assign hit_o.hit              = hit_q;
  assign hit_o.hit_distance     = dist_q;
  assign hit_o.nearest_found    = near_found_q;
  assign hit_o.nearest_distance = near_dist_q;

`ifndef ASSERT_OFF
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && hit_o.hit |-> hit_o.hit_distance != '0)
    else $error("hit word with zero distance");

  a_hit_nearest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && hit_o.hit |->
      hit_o.nearest_found && hit_o.nearest_distance <= hit_o.hit_distance)
    else $error("nearest record misses a hit");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o.valid && !hit_o.nearest_found |-> hit_o.nearest_distance == '0)
    else $error("nearest distance without a hit");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dt_q != '0)
    else $error("divide by zero determinant");
`endif

endmodule
